>>> rtl/assert_macros.svh
// Assertion helpers for the tokenizer; clocked on aclk, off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/stt_pkg.sv
package stt_pkg;

    // Widths of the internal counters
    localparam int LINE_BITS   = 16;
    localparam int COLUMN_BITS = 16;
    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;

    typedef logic [LINE_BITS-1:0]   line_t;
    typedef logic [COLUMN_BITS-1:0] col_t;
    typedef logic [OFFSET_BITS-1:0] off_t;
    typedef logic [LENGTH_BITS-1:0] len_t;

    // Result field types
    typedef logic [4:0]  kind_t;
    typedef logic [15:0] line_f_t;
    typedef logic [15:0] col_f_t;
    typedef logic [31:0] off_f_t;
    typedef logic [15:0] len_f_t;

    typedef struct packed {
        logic    last;
        len_f_t  length;
        off_f_t  offset;
        col_f_t  column;
        line_f_t line;
        kind_t   kind;
    } res_t;

    // Scan modes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IDENT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NUM   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EQ    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BANG  = 3'd4;

    // Token kinds
    localparam kind_t KIND_EOF      = 5'd0;
    localparam kind_t KIND_IDENT    = 5'd1;
    localparam kind_t KIND_NUMBER   = 5'd2;
    localparam kind_t KIND_KW_FIRST = 5'd3;
    localparam kind_t KIND_LPAREN   = 5'd9;
    localparam kind_t KIND_RPAREN   = 5'd10;
    localparam kind_t KIND_LBRACE   = 5'd11;
    localparam kind_t KIND_RBRACE   = 5'd12;
    localparam kind_t KIND_SEMI     = 5'd13;
    localparam kind_t KIND_COMMA    = 5'd14;
    localparam kind_t KIND_PLUS     = 5'd15;
    localparam kind_t KIND_MINUS    = 5'd16;
    localparam kind_t KIND_LESS     = 5'd17;
    localparam kind_t KIND_GREATER  = 5'd18;
    localparam kind_t KIND_ASSIGN   = 5'd19;
    localparam kind_t KIND_EQUAL    = 5'd20;
    localparam kind_t KIND_NOT      = 5'd21;
    localparam kind_t KIND_NOTEQUAL = 5'd22;
    localparam kind_t KIND_ERROR    = 5'd23;

    // Keywords, packed with the last byte lowest, in kind order
    localparam int KW_COUNT = 6;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0000_6966,     // if
        48'h0000_656c_7365,     // else
        48'h0000_766f_6964,     // void
        48'h0000_0069_6e74,     // int
        48'h0070_7269_6e74,     // print
        48'h7265_7475_726e      // return
    };
    localparam int KW_LEN [KW_COUNT] = '{2, 4, 4, 3, 5, 6};

endpackage

>>> rtl/source_text_tokenizer.sv
// A result is on m_* in the cycle after its input transfer.
// One input transfer per cycle while m_tready is high and each byte yields at most one token;
// an item yielding several results holds s_tready low until only its last is left (result buffer).
// Reset: aresetn low (synchronous) empties the result buffer, closes any open token and
// returns the position to line 1, column 1, offset 0.
`include "assert_macros.svh"

module source_text_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [4:0] token_kind, [20:5] start_line, [36:21] start_column,
                                   // [68:37] start_offset, [84:69] token_length, [87:85] zero
    output logic        m_tlast    // run_end
);

    // Scanner state
    logic [stt_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [47:0]                window_reg, window_next;
    stt_pkg::line_t             tok_line_reg, tok_line_next;
    stt_pkg::col_t              tok_col_reg, tok_col_next;
    stt_pkg::off_t              tok_off_reg, tok_off_next;
    stt_pkg::len_t              tok_len_reg, tok_len_next;
    stt_pkg::line_t             cur_line_reg, cur_line_next;
    stt_pkg::col_t              cur_col_reg, cur_col_next;
    stt_pkg::off_t              cur_off_reg, cur_off_next;
    logic                       lws_reg, lws_next;

    // Result buffer
    stt_pkg::res_t slot_reg [3];
    stt_pkg::res_t slot_next [3];
    logic [1:0]    cnt_reg, cnt_next;

    logic          accept, pop, eos;
    logic [7:0]    ch;
    logic          is_alpha, is_digit, is_space, is_word;
    logic [7:0]    ch_lower;
    stt_pkg::kind_t ident_kind, flush_kind, single_kind;
    stt_pkg::res_t flush_res, eof_res, single_res, pair_res;
    stt_pkg::res_t res_list [3];
    logic [1:0]    res_cnt;

    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;
    assign eos    = s_tuser;
    assign ch     = s_tdata;

    // Take a new item only when the buffer drains this cycle
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = slot_reg[0].last;
    assign m_tdata  = {3'b000, slot_reg[0].length, slot_reg[0].offset, slot_reg[0].column,
                       slot_reg[0].line, slot_reg[0].kind};

    // Classify the byte
    assign ch_lower = ch | 8'h20;
    assign is_alpha = (ch_lower >= 8'h61) && (ch_lower <= 8'h7a);
    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_space = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0d) || (ch == 8'h0a);
    assign is_word  = is_alpha || is_digit || (ch == 8'h5f);

    // Match the open identifier against the keywords
    always_comb begin
        ident_kind = stt_pkg::KIND_IDENT;
        for (int k = 0; k < stt_pkg::KW_COUNT; k++) begin
            if ((tok_len_reg == stt_pkg::len_t'(stt_pkg::KW_LEN[k])) &&
                (window_reg == stt_pkg::KW_TEXT[k])) begin
                ident_kind = stt_pkg::kind_t'(stt_pkg::KIND_KW_FIRST + stt_pkg::kind_t'(k));
            end
        end
    end

    // Kind of the open token when it closes
    always_comb begin
        case (mode_reg)
            stt_pkg::MODE_IDENT: flush_kind = ident_kind;
            stt_pkg::MODE_NUM:   flush_kind = stt_pkg::KIND_NUMBER;
            stt_pkg::MODE_EQ:    flush_kind = stt_pkg::KIND_ASSIGN;
            default:             flush_kind = stt_pkg::KIND_NOT;
        endcase
    end

    // Single-byte punctuation or error
    always_comb begin
        case (ch)
            8'h28:   single_kind = stt_pkg::KIND_LPAREN;
            8'h29:   single_kind = stt_pkg::KIND_RPAREN;
            8'h7b:   single_kind = stt_pkg::KIND_LBRACE;
            8'h7d:   single_kind = stt_pkg::KIND_RBRACE;
            8'h3b:   single_kind = stt_pkg::KIND_SEMI;
            8'h2c:   single_kind = stt_pkg::KIND_COMMA;
            8'h2b:   single_kind = stt_pkg::KIND_PLUS;
            8'h2d:   single_kind = stt_pkg::KIND_MINUS;
            8'h3c:   single_kind = stt_pkg::KIND_LESS;
            8'h3e:   single_kind = stt_pkg::KIND_GREATER;
            default: single_kind = stt_pkg::KIND_ERROR;
        endcase
    end

    // Candidate result records
    always_comb begin
        flush_res        = '0;
        flush_res.kind   = flush_kind;
        flush_res.line   = stt_pkg::line_f_t'(tok_line_reg);
        flush_res.column = stt_pkg::col_f_t'(tok_col_reg);
        flush_res.offset = stt_pkg::off_f_t'(tok_off_reg);
        flush_res.length = stt_pkg::len_f_t'(tok_len_reg);

        pair_res        = flush_res;
        pair_res.kind   = (mode_reg == stt_pkg::MODE_EQ) ? stt_pkg::KIND_EQUAL
                                                         : stt_pkg::KIND_NOTEQUAL;
        pair_res.length = stt_pkg::len_f_t'(2);

        eof_res        = '0;
        eof_res.kind   = stt_pkg::KIND_EOF;
        eof_res.line   = stt_pkg::line_f_t'(cur_line_reg);
        eof_res.column = stt_pkg::col_f_t'(cur_col_reg);
        eof_res.offset = stt_pkg::off_f_t'(cur_off_reg);

        single_res        = eof_res;
        single_res.kind   = single_kind;
        single_res.length = stt_pkg::len_f_t'(1);
    end

    // Scan one item: results and next state
    always_comb begin
        logic extend, pair, open_tok;
        extend = (mode_reg == stt_pkg::MODE_IDENT && is_word) ||
                 (mode_reg == stt_pkg::MODE_NUM && is_digit);
        pair   = (mode_reg == stt_pkg::MODE_EQ || mode_reg == stt_pkg::MODE_BANG) &&
                 (ch == 8'h3d);
        open_tok = 1'b0;

        res_list[0] = '0;
        res_list[1] = '0;
        res_list[2] = '0;
        res_cnt     = 2'd0;

        mode_next    = mode_reg;
        window_next  = window_reg;
        tok_line_next = tok_line_reg;
        tok_col_next = tok_col_reg;
        tok_off_next = tok_off_reg;
        tok_len_next = tok_len_reg;
        lws_next     = lws_reg;

        // Advance the position past this byte
        cur_off_next = (cur_off_reg == '1) ? cur_off_reg : cur_off_reg + 1'b1;
        if (ch == 8'h0a) begin
            cur_line_next = (cur_line_reg == '1) ? cur_line_reg : cur_line_reg + 1'b1;
            cur_col_next  = stt_pkg::col_t'(1);
        end else begin
            cur_line_next = cur_line_reg;
            cur_col_next  = (cur_col_reg == '1) ? cur_col_reg : cur_col_reg + 1'b1;
        end

        if (eos) begin
            // Flush, optional extra eof, final eof, then back to the start
            if (mode_reg != stt_pkg::MODE_IDLE) begin
                res_list[res_cnt] = flush_res;
                res_cnt = res_cnt + 2'd1;
            end
            if (lws_reg) begin
                res_list[res_cnt] = eof_res;
                res_cnt = res_cnt + 2'd1;
            end
            res_list[res_cnt] = eof_res;
            res_cnt = res_cnt + 2'd1;
            mode_next     = stt_pkg::MODE_IDLE;
            window_next   = '0;
            tok_line_next = stt_pkg::line_t'(1);
            tok_col_next  = stt_pkg::col_t'(1);
            tok_off_next  = '0;
            tok_len_next  = '0;
            cur_line_next = stt_pkg::line_t'(1);
            cur_col_next  = stt_pkg::col_t'(1);
            cur_off_next  = '0;
            lws_next      = 1'b0;
        end else if (extend) begin
            window_next  = {window_reg[39:0], ch};
            tok_len_next = (tok_len_reg == '1) ? tok_len_reg : tok_len_reg + 1'b1;
        end else if (pair) begin
            res_list[0] = pair_res;
            res_cnt     = 2'd1;
            mode_next   = stt_pkg::MODE_IDLE;
            lws_next    = 1'b0;
        end else begin
            // Close the open token, then start afresh with this byte
            if (mode_reg != stt_pkg::MODE_IDLE) begin
                res_list[0] = flush_res;
                res_cnt     = 2'd1;
            end
            mode_next = stt_pkg::MODE_IDLE;
            lws_next  = is_space;
            if (is_space) begin
                open_tok = 1'b0;
            end else if (is_alpha || ch == 8'h5f) begin
                mode_next = stt_pkg::MODE_IDENT;
                open_tok  = 1'b1;
            end else if (is_digit) begin
                mode_next = stt_pkg::MODE_NUM;
                open_tok  = 1'b1;
            end else if (ch == 8'h3d) begin
                mode_next = stt_pkg::MODE_EQ;
                open_tok  = 1'b1;
            end else if (ch == 8'h21) begin
                mode_next = stt_pkg::MODE_BANG;
                open_tok  = 1'b1;
            end else begin
                res_list[res_cnt] = single_res;
                res_cnt = res_cnt + 2'd1;
            end
            if (open_tok) begin
                tok_line_next = cur_line_reg;
                tok_col_next  = cur_col_reg;
                tok_off_next  = cur_off_reg;
                tok_len_next  = stt_pkg::len_t'(1);
                window_next   = {40'd0, ch};
            end
        end

        // Mark the last result of the item
        if (res_cnt != 2'd0) begin
            res_list[res_cnt - 2'd1].last = 1'b1;
        end
    end

    // Load or drain the result buffer
    always_comb begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        slot_next[2] = slot_reg[2];
        cnt_next     = cnt_reg;
        if (accept) begin
            slot_next[0] = res_list[0];
            slot_next[1] = res_list[1];
            slot_next[2] = res_list[2];
            cnt_next     = res_cnt;
        end else if (pop) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    // Control and position registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= 2'd0;
            mode_reg     <= stt_pkg::MODE_IDLE;
            window_reg   <= '0;
            tok_line_reg <= stt_pkg::line_t'(1);
            tok_col_reg  <= stt_pkg::col_t'(1);
            tok_off_reg  <= '0;
            tok_len_reg  <= '0;
            cur_line_reg <= stt_pkg::line_t'(1);
            cur_col_reg  <= stt_pkg::col_t'(1);
            cur_off_reg  <= '0;
            lws_reg      <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (accept) begin
                mode_reg     <= mode_next;
                window_reg   <= window_next;
                tok_line_reg <= tok_line_next;
                tok_col_reg  <= tok_col_next;
                tok_off_reg  <= tok_off_next;
                tok_len_reg  <= tok_len_next;
                cur_line_reg <= cur_line_next;
                cur_col_reg  <= cur_col_next;
                cur_off_reg  <= cur_off_next;
                lws_reg      <= lws_next;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        slot_reg[2] <= slot_next[2];
    end

    // End of source always leaves a result waiting
    `ASSERT_NEXT(a_eos_gives_result, accept && eos, cnt_reg != 2'd0)
    // An open token means the previous byte was not whitespace
    `ASSERT_IMP(a_open_not_space, mode_reg != stt_pkg::MODE_IDLE, !lws_reg)
    // Only the last buffered result carries the end mark
    `ASSERT_IMP(a_last_one, cnt_reg == 2'd1, slot_reg[0].last)
    `ASSERT_IMP(a_last_two, cnt_reg == 2'd2, slot_reg[1].last && !slot_reg[0].last)

endmodule

>>> verif/token_stream_checker.sv
module token_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,   // [4:0] token_kind, [20:5] start_line, [36:21] start_column,
                                   // [68:37] start_offset, [84:69] token_length, [87:85] zero
    input  logic        m_tlast,   // run_end
    output int          mismatch_count,
    output int          tokens_pending,
    output int          tokens_checked
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Lexer state as the block should hold it
    logic [stt_pkg::MODE_W-1:0] scan_mode;
    logic [47:0]                kw_window;
    stt_pkg::line_t             tok_line, cur_line;
    stt_pkg::col_t              tok_col, cur_col;
    stt_pkg::off_t              tok_off, cur_off;
    stt_pkg::len_t              tok_len;
    logic                       after_space;

    stt_pkg::res_t step_tokens[$];
    stt_pkg::res_t token_fifo[$];

    function automatic void clear_lexer();
        scan_mode   = stt_pkg::MODE_IDLE;
        kw_window   = '0;
        tok_line    = stt_pkg::line_t'(1);
        tok_col     = stt_pkg::col_t'(1);
        tok_off     = '0;
        tok_len     = '0;
        cur_line    = stt_pkg::line_t'(1);
        cur_col     = stt_pkg::col_t'(1);
        cur_off     = '0;
        after_space = 1'b0;
    endfunction

    function automatic bit is_letter(logic [7:0] ch);
        logic [7:0] low;
        low = ch | 8'h20;
        return low >= "a" && low <= "z";
    endfunction

    function automatic bit is_digit(logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic void emit_token(stt_pkg::kind_t kind, stt_pkg::line_t ln,
                                       stt_pkg::col_t cl, stt_pkg::off_t of,
                                       stt_pkg::len_t len);
        stt_pkg::res_t tok;
        tok.kind   = kind;
        tok.line   = stt_pkg::line_f_t'(ln);
        tok.column = stt_pkg::col_f_t'(cl);
        tok.offset = stt_pkg::off_f_t'(of);
        tok.length = stt_pkg::len_f_t'(len);
        tok.last   = 1'b0;
        step_tokens.push_back(tok);
    endfunction

    // Step past one byte; all counters saturate
    function automatic void advance_position(logic [7:0] ch);
        if (cur_off != '1) cur_off = cur_off + 1'b1;
        if (ch == CH_LF) begin
            if (cur_line != '1) cur_line = cur_line + 1'b1;
            cur_col = stt_pkg::col_t'(1);
        end else if (cur_col != '1) begin
            cur_col = cur_col + 1'b1;
        end
    endfunction

    function automatic void open_token(logic [stt_pkg::MODE_W-1:0] mode, logic [7:0] ch);
        scan_mode = mode;
        tok_line  = cur_line;
        tok_col   = cur_col;
        tok_off   = cur_off;
        tok_len   = stt_pkg::len_t'(1);
        kw_window = {40'd0, ch};
    endfunction

    // Keyword only when the whole identifier matches, not just its tail
    function automatic stt_pkg::kind_t word_kind();
        for (int k = 0; k < stt_pkg::KW_COUNT; k++) begin
            if (tok_len == stt_pkg::len_t'(stt_pkg::KW_LEN[k]) &&
                kw_window == stt_pkg::KW_TEXT[k])
                return stt_pkg::kind_t'(stt_pkg::KIND_KW_FIRST + k);
        end
        return stt_pkg::KIND_IDENT;
    endfunction

    function automatic void close_token();
        stt_pkg::kind_t kind;
        if (scan_mode == stt_pkg::MODE_IDLE) return;
        case (scan_mode)
            stt_pkg::MODE_IDENT: kind = word_kind();
            stt_pkg::MODE_NUM:   kind = stt_pkg::KIND_NUMBER;
            stt_pkg::MODE_EQ:    kind = stt_pkg::KIND_ASSIGN;
            default:             kind = stt_pkg::KIND_NOT;
        endcase
        emit_token(kind, tok_line, tok_col, tok_off, tok_len);
        scan_mode = stt_pkg::MODE_IDLE;
    endfunction

    // Work out the tokens that one input transfer releases
    function automatic void predict_tokens(logic end_of_source, logic [7:0] ch);
        stt_pkg::kind_t kind;
        step_tokens.delete();
        if (end_of_source) begin
            close_token();
            if (after_space)
                emit_token(stt_pkg::KIND_EOF, cur_line, cur_col, cur_off, '0);
            emit_token(stt_pkg::KIND_EOF, cur_line, cur_col, cur_off, '0);
            clear_lexer();
        end else if ((scan_mode == stt_pkg::MODE_IDENT
                      && (is_letter(ch) || is_digit(ch) || ch == "_"))
                     || (scan_mode == stt_pkg::MODE_NUM && is_digit(ch))) begin
            kw_window = {kw_window[39:0], ch};
            if (tok_len != '1) tok_len = tok_len + 1'b1;
            advance_position(ch);
        end else if ((scan_mode == stt_pkg::MODE_EQ || scan_mode == stt_pkg::MODE_BANG)
                     && ch == "=") begin
            emit_token((scan_mode == stt_pkg::MODE_EQ) ? stt_pkg::KIND_EQUAL
                                                       : stt_pkg::KIND_NOTEQUAL,
                       tok_line, tok_col, tok_off, stt_pkg::len_t'(2));
            scan_mode   = stt_pkg::MODE_IDLE;
            after_space = 1'b0;
            advance_position(ch);
        end else begin
            close_token();
            after_space = 1'b0;
            if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF) begin
                after_space = 1'b1;
            end else if (is_letter(ch) || ch == "_") begin
                open_token(stt_pkg::MODE_IDENT, ch);
            end else if (is_digit(ch)) begin
                open_token(stt_pkg::MODE_NUM, ch);
            end else if (ch == "=") begin
                open_token(stt_pkg::MODE_EQ, ch);
            end else if (ch == "!") begin
                open_token(stt_pkg::MODE_BANG, ch);
            end else begin
                case (ch)
                    "(":     kind = stt_pkg::KIND_LPAREN;
                    ")":     kind = stt_pkg::KIND_RPAREN;
                    "{":     kind = stt_pkg::KIND_LBRACE;
                    "}":     kind = stt_pkg::KIND_RBRACE;
                    ";":     kind = stt_pkg::KIND_SEMI;
                    ",":     kind = stt_pkg::KIND_COMMA;
                    "+":     kind = stt_pkg::KIND_PLUS;
                    "-":     kind = stt_pkg::KIND_MINUS;
                    "<":     kind = stt_pkg::KIND_LESS;
                    ">":     kind = stt_pkg::KIND_GREATER;
                    default: kind = stt_pkg::KIND_ERROR;
                endcase
                emit_token(kind, cur_line, cur_col, cur_off, stt_pkg::len_t'(1));
            end
            advance_position(ch);
        end
        // Mark the last token of this transfer and queue them all
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) token_fifo.push_back(step_tokens[i]);
    endfunction

    // Watch both channels at each rising edge
    always @(posedge aclk) begin
        stt_pkg::res_t seen;
        stt_pkg::res_t want;
        if (!aresetn) begin
            clear_lexer();
            token_fifo.delete();
        end else begin
            if (s_tvalid && s_tready) predict_tokens(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                seen.kind   = m_tdata[4:0];
                seen.line   = m_tdata[20:5];
                seen.column = m_tdata[36:21];
                seen.offset = m_tdata[68:37];
                seen.length = m_tdata[84:69];
                seen.last   = m_tlast;
                tokens_checked++;
                if (token_fifo.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: token with none expected: kind %0d line %0d col %0d",
                                 $realtime, seen.kind, seen.line, seen.column);
                    mismatch_count++;
                end else begin
                    want = token_fifo.pop_front();
                    if (seen.kind !== want.kind || seen.line !== want.line
                        || seen.column !== want.column || seen.offset !== want.offset
                        || seen.length !== want.length || seen.last !== want.last) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: token %0d differs", $realtime, tokens_checked);
                            $display("  expected kind %0d line %0d col %0d off %0d len %0d last %0b",
                                     want.kind, want.line, want.column, want.offset,
                                     want.length, want.last);
                            $display("  actual   kind %0d line %0d col %0d off %0d len %0d last %0b",
                                     seen.kind, seen.line, seen.column, seen.offset,
                                     seen.length, seen.last);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
        tokens_pending = token_fifo.size();
    end

endmodule

>>> verif/tb_source_text_tokenizer.sv
module tb_source_text_tokenizer;

    typedef struct {
        logic       eos;
        logic [7:0] ch;
    } src_item_t;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_CR  = 8'h0D;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tlast;

    int mismatch_count;
    int tokens_pending;
    int tokens_checked;
    int items_sent    = 0;
    int sources_built = 0;
    bit hold_results  = 1'b0;

    src_item_t src_items[$];

    string keywords[6] = '{"if", "else", "void", "int", "print", "return"};
    string word_head   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string word_tail   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string punctuation = "(){};,+-<>";
    string operators[4] = '{"=", "==", "!", "!="};

    source_text_tokenizer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    token_stream_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .tokens_pending (tokens_pending),
        .tokens_checked (tokens_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void push_byte(logic [7:0] ch);
        src_item_t it;
        it.eos = 1'b0;
        it.ch  = ch;
        src_items.push_back(it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    // End of source; the byte rides along and is ignored
    function automatic void push_end();
        src_item_t it;
        it.eos = 1'b1;
        it.ch  = 8'($urandom_range(0, 255));
        src_items.push_back(it);
        sources_built++;
    endfunction

    function automatic logic [7:0] pick_char(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // A byte the lexer can only take as an error token
    function automatic logic [7:0] stray_byte();
        logic [7:0] ch;
        do begin
            ch = 8'($urandom_range(0, 255));
        end while ((ch | 8'h20) inside {["a":"z"]} || ch inside {["0":"9"]}
                   || ch inside {"_", "=", "!", " ", CH_TAB, CH_CR, CH_LF}
                   || ch inside {"(", ")", "{", "}", ";", ",", "+", "-", "<", ">"});
        return ch;
    endfunction

    // One short program: random tokens, mostly well formed, with some noise
    function automatic void build_source();
        int count;
        int pick;
        int size;
        if ($urandom_range(0, 14) == 0) begin
            push_end();
            return;
        end
        count = $urandom_range(1, 10);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                // keyword, now and then with a leading letter or underscore so only its tail matches
                if ($urandom_range(0, 3) == 0) push_byte(pick_char(word_head));
                push_text(keywords[$urandom_range(0, 5)]);
                if ($urandom_range(0, 5) == 0) push_byte(pick_char(word_tail));
            end else if (pick < 40) begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                push_byte(pick_char(word_head));
                repeat (size - 1) push_byte(pick_char(word_tail));
            end else if (pick < 55) begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range("0", "9")));
            end else if (pick < 75) begin
                push_byte(pick_char(punctuation));
            end else if (pick < 87) begin
                push_text(operators[$urandom_range(0, 3)]);
            end else if (pick < 95) begin
                push_byte(stray_byte());
            end else begin
                push_byte(8'($urandom_range(0, 255)));
            end
            // separator: often none, so tokens abut
            case ($urandom_range(0, 5))
                2: push_byte(" ");
                3: push_byte(CH_TAB);
                4: push_byte(CH_LF);
                5: begin
                    push_byte(CH_CR);
                    push_byte(CH_LF);
                end
                default: ;
            endcase
        end
        push_end();
    endfunction

    // Gap before the next transfer; flip now and then between busy and idle stretches
    function automatic int next_wait(inout bit steady);
        if ($urandom_range(0, 29) == 0) steady = !steady;
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    // Sender: reset, then offer every item in turn
    initial begin
        int gap;
        bit send_steady;
        send_steady = 1'b0;

        // directed sources: empty, operators and errors, trailing whitespace, open token at end
        push_end();
        push_text("if(_9==0)!x!=");
        push_byte(CH_VT);
        push_byte(8'hFF);
        push_text(" ");
        push_byte(CH_LF);
        push_end();
        push_text("=x1");
        push_end();
        while (src_items.size() < 400) build_source();

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < src_items.size(); i++) begin
            gap = next_wait(send_steady);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= src_items[i].eos;
            s_tdata  <= src_items[i].ch;
            do @(posedge aclk); while (s_tready !== 1'b1);
            items_sent++;
            @(negedge aclk);
        end
        s_tvalid <= 1'b0;

        // drain, then wait a little longer for anything stray
        wait (tokens_pending == 0);
        repeat (10) @(posedge aclk);
        $display("Sent %0d byte and end-of-source transfers over %0d sources", items_sent,
                 sources_built);
        $display("Checked %0d token transfers, including a long result back-pressure stretch",
                 tokens_checked);
        if (mismatch_count == 0 && tokens_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: random stalls between token transfers, forced low during the hold
    initial begin
        int stall_left;
        bit recv_steady;
        stall_left  = 0;
        recv_steady = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_results || stall_left > 0) begin
                m_tready <= 1'b0;
                if (!hold_results) stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) stall_left = next_wait(recv_steady);
        end
    end

    // Hold results off long enough for the block to back up onto its input
    initial begin
        wait (items_sent >= 150);
        @(posedge aclk);
        hold_results = 1'b1;
        repeat (300) @(posedge aclk);
        hold_results = 1'b0;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
